// ===== rtl/variable_length_record_buffer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the variable-length record buffer
// Clocked assertion macros that report through $error; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_RECORD_BUFFER_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define VLRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define VLRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VLRB_ASSERT(lbl, prop, msg)
`define VLRB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/vlrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable-length record buffer package
// Command and status codes and the word types of the two channels.
// ----------------------------------------------------------------------------
package vlrb_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NO_SPACE = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] record_id;
    logic [11:0] length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [11:0] offset;
    logic [11:0] out_length;
    logic        now_empty;
    logic        now_full;
  } rsp_t;

endpackage

// ===== rtl/vlrb_chan_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface vlrb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/variable_length_record_buffer_top.sv =====
// ----------------------------------------------------------------------------
// Variable-length record buffer
// FIFO of record descriptors over a byte arena with a head and a tail free
// region; one put, get or clear command in, one response word out.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Word
//   --------+-----------+-----------------------------------------------------
//   cmd_i   | in        | command, record_id, length
//   rsp_o   | out       | status, out_id, offset, out_length, now_empty,
//           |           | now_full
//
// A put, a clear and a get on an empty queue load the response when taken.
// A get of a queued record goes through the get state: the descriptor memory
// returns its entry in the cycle after the read, when the space is released.
// The response register lets a new command be taken in the same cycle as the
// previous response leaves; while the response is stalled no command is taken.
// Reset is asynchronous and active low; it restores the arena and empties the
// queue; the descriptor memory itself is not cleared.

`include "variable_length_record_buffer_top_assert.svh"

module variable_length_record_buffer_top
  import vlrb_pkg::*;
#(
  parameter int BUF_BYTES   = 4096,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vlrb_chan_if.sink   cmd_i,
  vlrb_chan_if.source rsp_o
);

  // Arena pointers must hold the buffer size itself.
  localparam int AW = $clog2(BUF_BYTES + 1);
  // Width in which a size is compared with a 12-bit length.
  localparam int EW = (AW > 12) ? AW : 12;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GET  = 1'b1;

  typedef struct packed {
    logic [31:0]   id;
    logic [AW-1:0] off;
    logic [11:0]   len;
  } entry_t;

  localparam logic [AW-1:0] BufSize = AW'(BUF_BYTES);

  // Arena and queue control state.
  logic [AW-1:0] head_start_q, head_start_d;
  logic [AW-1:0] head_size_q, head_size_d;
  logic [AW-1:0] tail_start_q, tail_start_d;
  logic [AW-1:0] tail_size_q, tail_size_d;
  logic [AW-1:0] last_end_q, last_end_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          state_q, state_d;

  // Descriptor memory with a registered read port.
  entry_t        mem_q [QUEUE_DEPTH];
  entry_t        rd_entry_q;
  logic          mem_we;
  entry_t        mem_wdata;
  logic          mem_re;

  // Response register.
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_load;

  logic          cmd_fire;
  logic          q_empty, q_full;
  logic [EW-1:0] len_ext;
  logic          use_tail, use_head;
  logic [AW-1:0] put_off;
  logic [EW-1:0] off_ext;

  // Release path signals.
  logic [AW-1:0] rel_hstart, rel_hsize, rel_tstart, rel_tsize;
  logic [AW:0]   rel_hend;
  logic [EW-1:0] rel_grow;
  logic [AW-1:0] rel_len;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  assign cmd_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign q_empty = (cnt_q == '0);
  assign q_full  = (cnt_q >= CW'(QUEUE_DEPTH));
  assign len_ext = EW'(cmd_i.data.length);

  // A put continues in the tail region only when it follows the last record.
  assign use_tail = (last_end_q == tail_start_q) && (EW'(tail_size_q) > len_ext);
  assign use_head = EW'(head_size_q) > len_ext;
  assign put_off  = use_tail ? tail_start_q : head_start_q;

  // Space release for the entry just read back: bytes below the head region
  // make the old head the tail; otherwise the head grows, and the regions
  // merge once the head reaches the tail.
  always_comb begin
    rel_len    = AW'(EW'(rd_entry_q.len));
    rel_hstart = head_start_q;
    rel_hsize  = head_size_q;
    rel_tstart = tail_start_q;
    rel_tsize  = tail_size_q;
    rel_grow   = EW'(head_size_q) + EW'(rd_entry_q.len);
    if (rd_entry_q.off < head_start_q) begin
      rel_tstart = head_start_q;
      rel_tsize  = head_size_q;
      rel_hstart = rd_entry_q.off;
      rel_hsize  = rel_len;
    end else begin
      rel_hsize = rel_grow[AW-1:0];
    end
    rel_hend = {1'b0, rel_hstart} + {1'b0, rel_hsize};
    if (rel_hend == {1'b0, rel_tstart}) begin
      rel_hsize  = rel_hsize + rel_tsize;
      rel_tstart = BufSize;
      rel_tsize  = '0;
    end
  end

  always_comb begin
    head_start_d = head_start_q;
    head_size_d  = head_size_q;
    tail_start_d = tail_start_q;
    tail_size_d  = tail_size_q;
    last_end_d   = last_end_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    cnt_d        = cnt_q;
    state_d      = state_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = '{id: cmd_i.data.record_id, off: put_off, len: cmd_i.data.length};
    rsp_load     = 1'b0;
    rsp_d        = '0;
    off_ext      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          rsp_load     = 1'b1;
          rsp_d.status = STS_OK;
          unique case (cmd_i.data.command)
            CMD_PUT: begin
              if (q_full) begin
                rsp_d.status = STS_FULL;
              end else if (use_tail || use_head) begin
                if (use_tail) begin
                  tail_start_d = tail_start_q + AW'(len_ext);
                  tail_size_d  = tail_size_q - AW'(len_ext);
                end else begin
                  head_start_d = head_start_q + AW'(len_ext);
                  head_size_d  = head_size_q - AW'(len_ext);
                end
                mem_we           = 1'b1;
                wr_ptr_d         = ptr_inc(wr_ptr_q);
                cnt_d            = cnt_q + CW'(1);
                last_end_d       = put_off + AW'(len_ext);
                off_ext          = EW'(put_off);
                rsp_d.offset     = off_ext[11:0];
                rsp_d.out_length = cmd_i.data.length;
              end else begin
                rsp_d.status = STS_NO_SPACE;
              end
            end
            CMD_GET: begin
              if (q_empty) begin
                rsp_d.status = STS_EMPTY;
              end else begin
                // The entry comes back next cycle; respond from there.
                rsp_load = 1'b0;
                mem_re   = 1'b1;
                state_d  = ST_GET;
              end
            end
            CMD_CLEAR: begin
              if (q_empty) begin
                head_start_d = '0;
                head_size_d  = BufSize;
                tail_start_d = BufSize;
                tail_size_d  = '0;
                last_end_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_GET: begin
        rsp_load         = 1'b1;
        rd_ptr_d         = ptr_inc(rd_ptr_q);
        cnt_d            = cnt_q - CW'(1);
        if (rd_entry_q.len != '0) begin
          head_start_d = rel_hstart;
          head_size_d  = rel_hsize;
          tail_start_d = rel_tstart;
          tail_size_d  = rel_tsize;
        end
        off_ext          = EW'(rd_entry_q.off);
        rsp_d.status     = STS_OK;
        rsp_d.out_id     = rd_entry_q.id;
        rsp_d.offset     = off_ext[11:0];
        rsp_d.out_length = rd_entry_q.len;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rsp_d.now_empty = (cnt_d == '0);
    rsp_d.now_full  = (cnt_d >= CW'(QUEUE_DEPTH));
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_start_q <= '0;
      head_size_q  <= BufSize;
      tail_start_q <= BufSize;
      tail_size_q  <= '0;
      last_end_q   <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      cnt_q        <= '0;
      state_q      <= ST_IDLE;
      rsp_valid_q  <= 1'b0;
    end else begin
      head_start_q <= head_start_d;
      head_size_q  <= head_size_d;
      tail_start_q <= tail_start_d;
      tail_size_q  <= tail_size_d;
      last_end_q   <= last_end_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      cnt_q        <= cnt_d;
      state_q      <= state_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  // The memory is written and read in separate cycles: a get only reads an
  // entry that a put wrote in an earlier cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry_q <= mem_q[rd_ptr_q];
    end
  end

  `VLRB_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `VLRB_ASSERT(a_get_rsp_free, (state_q == ST_GET) |-> !rsp_valid_q,
               "response register busy while a get completes")
  `VLRB_ASSERT(a_get_done, (state_q == ST_GET) |=> (rsp_valid_q && state_q == ST_IDLE),
               "get did not produce a response")
  `VLRB_ASSERT(a_free_bound,
               ({1'b0, head_size_q} + {1'b0, tail_size_q}) <= {1'b0, BufSize},
               "free regions exceed the arena")
  `VLRB_ASSERT(a_get_read, (cmd_fire && cmd_i.data.command == CMD_GET && !q_empty) |=>
               (state_q == ST_GET), "get of a queued record did not read the memory")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Variable-length record buffer testbench
// Sends put, get, clear and idle commands over the command channel. A local
// model of the free regions and the descriptor queue predicts every response
// word, and each response is checked field by field in order. Both sides
// idle and stall at random in changing proportions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import vlrb_pkg::*;
();

  localparam int BUF_BYTES   = 4096;
  localparam int QUEUE_DEPTH = 16;

  // The command field is two bits wide, so the fourth code must be sent too;
  // the block treats it as a no-operation.
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam int RANDOM_WORDS = 1000;
  localparam int SETTLE_CYCLES = 10;

  // Descriptor of one queued record, as the local model keeps it.
  typedef struct {
    logic [31:0] id;
    logic [11:0] off;
    logic [11:0] len;
  } record_t;

  logic clk_i;
  logic rst_ni;

  vlrb_chan_if #(.T(cmd_t)) cmd_if ();
  vlrb_chan_if #(.T(rsp_t)) rsp_if ();

  variable_length_record_buffer_top #(
    .BUF_BYTES  (BUF_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  // Command words waiting to be sent, and response words still owed.
  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];

  // Local copy of the arena's two free regions and the descriptor queue.
  logic [12:0] head_start;
  logic [12:0] head_size;
  logic [12:0] tail_start;
  logic [12:0] tail_size;
  logic [12:0] last_end;
  record_t     queued_records[$];

  int accepted_cmds;
  int total_cmds;
  int mismatch_count;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The run is split into thirds by the number of command words taken: first
  // the sender idles lightly and the receiver stalls heavily, then the other
  // way round, and in the last third neither side holds back at all.
  function automatic int unsigned idle_percent(bit for_sender);
    int phase;
    phase = (total_cmds == 0) ? 0 : (accepted_cmds * 3) / total_cmds;
    case (phase)
      0:       return for_sender ? 20 : 61;
      1:       return for_sender ? 61 : 20;
      default: return 0;
    endcase
  endfunction

  // Restores both free regions to their state after reset. The descriptor
  // queue is left alone, just as a clear leaves the queue pointers.
  function automatic void reset_arena();
    head_start = '0;
    head_size  = 13'(BUF_BYTES);
    tail_start = 13'(BUF_BYTES);
    tail_size  = '0;
    last_end   = '0;
  endfunction

  // Returns the space of a dequeued record. Bytes lying below the head region
  // mean the allocator has wrapped: the old head region becomes the tail
  // region and the freed bytes start a new head region. Otherwise the head
  // region simply grows. Once the head region runs into the tail region the
  // two are merged into one.
  function automatic void free_record_space(logic [11:0] off, logic [11:0] len);
    if (len == '0) begin
      return;
    end
    if (13'(off) < head_start) begin
      tail_start = head_start;
      tail_size  = head_size;
      head_start = 13'(off);
      head_size  = 13'(len);
    end else begin
      head_size = head_size + 13'(len);
    end
    if (14'(head_start) + 14'(head_size) == 14'(tail_start)) begin
      head_size  = head_size + tail_size;
      tail_start = 13'(BUF_BYTES);
      tail_size  = '0;
    end
  endfunction

  // Works out the response word that a command causes and moves the local
  // state on. Fields that a command does not use stay zero.
  function automatic rsp_t predict_response(cmd_t c);
    rsp_t    r;
    record_t rec;
    bit      placed;
    r        = '0;
    r.status = STS_OK;
    placed   = 1'b0;
    case (c.command)
      CMD_PUT: begin
        if (queued_records.size() >= QUEUE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          // A put carries on in the tail region only when the previous one
          // ended exactly at its start; the chosen region must be strictly
          // larger than the length asked for.
          if (last_end == tail_start && tail_size > 13'(c.length)) begin
            rec.off    = tail_start[11:0];
            tail_start = tail_start + 13'(c.length);
            tail_size  = tail_size - 13'(c.length);
            placed     = 1'b1;
          end else if (head_size > 13'(c.length)) begin
            rec.off    = head_start[11:0];
            head_start = head_start + 13'(c.length);
            head_size  = head_size - 13'(c.length);
            placed     = 1'b1;
          end
          if (placed) begin
            rec.id  = c.record_id;
            rec.len = c.length;
            queued_records.push_back(rec);
            last_end     = 13'(rec.off) + 13'(rec.len);
            r.offset     = rec.off;
            r.out_length = rec.len;
          end else begin
            r.status = STS_NO_SPACE;
          end
        end
      end
      CMD_GET: begin
        if (queued_records.size() == 0) begin
          r.status = STS_EMPTY;
        end else begin
          rec          = queued_records.pop_front();
          r.out_id     = rec.id;
          r.offset     = rec.off;
          r.out_length = rec.len;
          free_record_space(rec.off, rec.len);
        end
      end
      CMD_CLEAR: begin
        if (queued_records.size() == 0) begin
          reset_arena();
        end
      end
      default: begin
      end
    endcase
    r.now_empty = (queued_records.size() == 0);
    r.now_full  = (queued_records.size() >= QUEUE_DEPTH);
    return r;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_response(rsp_t got);
    rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("response word with no command outstanding: 0x%0h", got);
      mismatch_count++;
      return;
    end
    want = expected_rsps.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("out_id", want.out_id, got.out_id);
    compare_field("offset", want.offset, got.offset);
    compare_field("out_length", want.out_length, got.out_length);
    compare_field("now_empty", want.now_empty, got.now_empty);
    compare_field("now_full", want.now_full, got.now_full);
  endfunction

  function automatic void queue_cmd(logic [1:0] command, logic [31:0] id,
                                    logic [11:0] len);
    cmd_t c;
    c.command   = command;
    c.record_id = id;
    c.length    = len;
    pending_cmds.push_back(c);
  endfunction

  // Lengths lean towards small records so that many fit at once and the
  // queue fills up, with some large ones to run the arena out of space and
  // an occasional draw over the whole field.
  function automatic logic [11:0] random_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return '0;
    end else if (pick < 60) begin
      return 12'($urandom_range(200, 1));
    end else if (pick < 85) begin
      return 12'($urandom_range(1200, 201));
    end else if (pick < 95) begin
      return 12'($urandom_range(3000, 1201));
    end
    return 12'($urandom_range(4095, 0));
  endfunction

  function automatic logic [1:0] random_command();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return CMD_PUT;
    end else if (pick < 80) begin
      return CMD_GET;
    end else if (pick < 93) begin
      return CMD_CLEAR;
    end
    return CMD_NOP;
  endfunction

  // Directed opening: empty and full queue, no space, a zero-length record,
  // clears on a busy and an idle queue, a wrap that hands the old head region
  // over as the tail region and merges it back, and a put that carries on in
  // the tail region.
  function automatic void build_directed();
    queue_cmd(CMD_GET, 32'h0, 12'h0);
    queue_cmd(CMD_PUT, 32'hFFFF_FFFF, 12'hFFF);
    queue_cmd(CMD_PUT, 32'h0, 12'h0);
    queue_cmd(CMD_PUT, 32'h1234_5678, 12'h001);
    queue_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 12'hFFF);
    queue_cmd(CMD_GET, 32'hA5A5_A5A5, 12'hA5A);
    queue_cmd(CMD_GET, 32'h5A5A_5A5A, 12'h5A5);
    queue_cmd(CMD_CLEAR, 32'h0, 12'h0);
    queue_cmd(CMD_NOP, 32'hFFFF_FFFF, 12'hFFF);
    queue_cmd(CMD_PUT, 32'h0000_0010, 12'd2000);
    queue_cmd(CMD_PUT, 32'h0000_0011, 12'd2000);
    queue_cmd(CMD_GET, 32'h0, 12'h0);
    queue_cmd(CMD_PUT, 32'h0000_0012, 12'd50);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      queue_cmd(CMD_PUT, $urandom(), 12'd1);
    end
  endfunction

  // Random part: bursts of puts fill the queue and the arena, bursts of gets
  // drain them and drive the wrap and merge paths, and mixed stretches add
  // clears, no-operations and commands with arbitrary content.
  function automatic void build_random(int target);
    int unsigned mode;
    int unsigned burst;
    while (pending_cmds.size() < target) begin
      mode  = $urandom_range(99);
      burst = $urandom_range(18, 1);
      for (int i = 0; i < burst; i++) begin
        if (mode < 35) begin
          queue_cmd(CMD_PUT, $urandom(), random_length());
        end else if (mode < 70) begin
          queue_cmd(CMD_GET, $urandom(), 12'($urandom()));
        end else begin
          queue_cmd(random_command(), $urandom(), random_length());
        end
      end
    end
  endfunction

  // Command driver: a new word is offered once the current one has been
  // taken, or when nothing is on offer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data  <= '0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= pending_cmds.pop_front();
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Response receiver: stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_percent(1'b0));
    end
  end

  // Monitor: each command word taken updates the local model and adds one
  // expected response; each response word taken is checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_rsps.push_back(predict_response(cmd_if.data));
        accepted_cmds <= accepted_cmds + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        check_response(rsp_if.data);
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    rsp_if.ready   = 1'b0;
    accepted_cmds  = 0;
    mismatch_count = 0;
    reset_arena();
    build_directed();
    build_random(pending_cmds.size() + RANDOM_WORDS);
    total_cmds = pending_cmds.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every command to be taken and every response to arrive, then
    // give the block time to show any stray response.
    while (pending_cmds.size() != 0 || cmd_if.valid) begin
      @(posedge clk_i);
    end
    while (expected_rsps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_rsps.size() != 0) begin
      $error("%0d response words never arrived", expected_rsps.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vlrb_pkg.sv
rtl/vlrb_chan_if.sv
rtl/variable_length_record_buffer_top.sv
sim/tb.sv
